/* rtl/stereo_rms_compressor_top_macros.svh */
// Assertion macros shared by the checker files.
`ifndef STEREO_RMS_COMPRESSOR_TOP_MACROS_SVH
`define STEREO_RMS_COMPRESSOR_TOP_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define SRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define SRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs through reset.
`define SRC_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/src_pkg.sv */
`default_nettype none
package src_pkg;

    localparam int WINDOW_LEN_DEF = 48;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int SUM_W    = 21;
    localparam int ENV_W    = 17;
    localparam int DIFF_W   = ENV_W + 1;
    localparam int COEF_W   = 11;
    localparam int SLOPE_W  = 8;
    localparam int SCALE_W  = 6;
    localparam int GAIN_W   = 11;
    localparam int CFG_W    = 17;
    localparam int CFG_AW   = 3;
    localparam int TDATA_W  = 2 * SAMPLE_W;
    localparam int STEP_W   = 4;

    // shared multiplier: signed 22 x signed 12
    localparam int OPA_W    = 22;
    localparam int OPB_W    = 12;
    localparam int PROD_W   = OPA_W + OPB_W;
    localparam int FRAC     = 10;   // /1024
    localparam int CUT_FRAC = 8;    // /256

    localparam logic [ENV_W-1:0]   THRESHOLD_RST = 17'd12288;
    localparam logic [COEF_W-1:0]  ATTACK_RST    = 11'd900;
    localparam logic [COEF_W-1:0]  RELEASE_RST   = 11'd1019;
    localparam logic [SLOPE_W-1:0] SLOPE_RST     = 8'd12;
    localparam logic [SCALE_W-1:0] SCALE_RST     = 6'd21;
    localparam logic [COEF_W-1:0]  UNITY         = 11'd1024;
    localparam logic [ENV_W-1:0]   CUT_UNITY     = 17'd1024;

    typedef enum logic [CFG_AW-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_ATTACK    = 3'd1,
        REG_RELEASE   = 3'd2,
        REG_SLOPE     = 3'd3,
        REG_SCALE     = 3'd4
    } t_reg_idx;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_IDLE    = 4'd0;
    localparam t_step S_SUM     = 4'd1;
    localparam t_step S_MLEVEL  = 4'd2;
    localparam t_step S_DLEVEL  = 4'd3;
    localparam t_step S_MENV    = 4'd4;
    localparam t_step S_ENV     = 4'd5;
    localparam t_step S_DTHR    = 4'd6;
    localparam t_step S_MCUT    = 4'd7;
    localparam t_step S_GAIN    = 4'd8;
    localparam t_step S_MLEFT   = 4'd9;
    localparam t_step S_MRIGHT  = 4'd10;
    localparam t_step S_OUT     = 4'd11;
    localparam t_step PROG_LAST = S_OUT;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SUM,
        OP_DIFF_LVL,
        OP_ENV,
        OP_DIFF_THR,
        OP_GAIN,
        OP_HOLD_L,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_LEVEL,
        MUL_ENV,
        MUL_CUT,
        MUL_LEFT,
        MUL_RIGHT
    } t_mul;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_IN,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_mul  mul;
        t_cond cond;
        t_step tgt;
    } t_uop;

    // control store: jump to tgt while cond holds, else fall through
    function automatic t_uop uop_rom(input t_step step);
        t_uop u;
        u.op   = OP_NOP;
        u.mul  = MUL_NONE;
        u.cond = COND_NEVER;
        u.tgt  = S_IDLE;
        case (step)
            S_IDLE: begin
                u.op   = OP_LOAD;
                u.cond = COND_NO_IN;
                u.tgt  = S_IDLE;
            end
            S_SUM:    u.op  = OP_SUM;
            S_MLEVEL: u.mul = MUL_LEVEL;
            S_DLEVEL: u.op  = OP_DIFF_LVL;
            S_MENV:   u.mul = MUL_ENV;
            S_ENV:    u.op  = OP_ENV;
            S_DTHR:   u.op  = OP_DIFF_THR;
            S_MCUT:   u.mul = MUL_CUT;
            S_GAIN:   u.op  = OP_GAIN;
            S_MLEFT:  u.mul = MUL_LEFT;
            S_MRIGHT: begin
                u.op  = OP_HOLD_L;
                u.mul = MUL_RIGHT;
            end
            S_OUT: begin
                u.op   = OP_OUT;
                u.cond = COND_OUT_BUSY;
                u.tgt  = S_OUT;
            end
            default: u.op = OP_NOP;
        endcase
        return u;
    endfunction

    // |x|, with the most negative code saturating
    function automatic logic [MAG_W-1:0] mag15(input logic signed [SAMPLE_W-1:0] x);
        logic [SAMPLE_W-1:0] neg;
        neg = SAMPLE_W'(-x);
        if (x == 16'sh8000) begin
            return {MAG_W{1'b1}};
        end else if (x[SAMPLE_W-1]) begin
            return neg[MAG_W-1:0];
        end else begin
            return x[MAG_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/src_ram.sv */
`default_nettype none
module src_ram #(
    parameter  int WIDTH = 30,
    parameter  int DEPTH = 48,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/stereo_rms_compressor_top.sv */
// Stereo compressor with an RMS-like level detector.
// Input channel s_axis: one beat carries a stereo sample pair (left in the low
// half of tdata, right in the high half). Output channel m_axis: one beat per
// input beat with both samples scaled by the current gain, same packing.
// Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
// (0 threshold, 1 attack, 2 release, 3 slope, 4 level scale); other indexes
// are dropped. Write only while no beat is in flight.
// Sequencing: a microcoded sequencer runs a 12-step program per beat. The single
// shared 22x12 multiplier serves five of the steps (level, envelope, gain
// cut, left, right); a new beat is taken only once the program for the
// previous one has run through.
// s_axis_tready is high only on the idle step.
// Output stall: the finished beat sits in the output register; the next pair
// can be taken and worked on meanwhile, and the program waits on its last
// step until the output register frees up.
// Reset (synchronous, active low): registers back to defaults, envelope,
// sum and pointer to zero, every window slot marked empty (reads as zero),
// so no clearing pass is needed.
`default_nettype none
module stereo_rms_compressor_top #(
    parameter int WINDOW_LEN = src_pkg::WINDOW_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config write port
    input  logic                         i_cfg_we,
    input  logic [src_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [src_pkg::CFG_W-1:0]    i_cfg_wdata,
    // input pairs
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [src_pkg::TDATA_W-1:0]  s_axis_tdata,   // [15:0] left_in, [31:16] right_in
    // output pairs
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [src_pkg::TDATA_W-1:0]  m_axis_tdata    // [15:0] left_out, [31:16] right_out
);
    import src_pkg::*;

    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int WIN_W = 2 * MAG_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

    // sequencer
    t_step r_step;
    t_step n_step;
    t_uop  uop;
    logic  jump;
    logic  in_beat;
    logic  out_load;

    // config
    logic [ENV_W-1:0]   r_thr;
    logic [COEF_W-1:0]  r_atk;
    logic [COEF_W-1:0]  r_rel;
    logic [SLOPE_W-1:0] r_slope;
    logic [SCALE_W-1:0] r_scale;

    // state
    logic [PTR_W-1:0]      r_ptr;
    logic [WINDOW_LEN-1:0] r_valid;
    logic [SUM_W-1:0]      r_sum;
    logic [SUM_W-1:0]      n_sum;
    logic [ENV_W-1:0]      r_env;

    // datapath
    logic signed [SAMPLE_W-1:0] r_left;
    logic signed [SAMPLE_W-1:0] r_right;
    logic [MAG_W-1:0]           r_mag_l;
    logic [MAG_W-1:0]           r_mag_r;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [DIFF_W-1:0]   r_diff;
    logic [GAIN_W-1:0]          r_gain;
    logic [SAMPLE_W-1:0]        r_res_l;
    logic                       r_ovalid;
    logic [TDATA_W-1:0]         r_out;

    logic                     ram_we;
    logic [WIN_W-1:0]         ram_rdata;
    logic [MAG_W:0]           old_pair;
    logic [MAG_W:0]           new_pair;
    logic [MAG_W-1:0]         old_avg;
    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic [COEF_W-1:0]        coef_raw;
    logic [COEF_W-1:0]        coef;
    logic signed [PROD_W-FRAC-1:0] env_sum;
    logic [ENV_W-1:0]         cut;

    // ---------------- sequencer ----------------
    assign uop = uop_rom(r_step);

    always_comb begin
        case (uop.cond)
            COND_NEVER:    jump = 1'b0;
            COND_NO_IN:    jump = !s_axis_tvalid;
            COND_OUT_BUSY: jump = r_ovalid && !m_axis_tready;
            default:       jump = 1'b0;
        endcase
        if (jump) begin
            n_step = uop.tgt;
        end else if (r_step == PROG_LAST) begin
            n_step = S_IDLE;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    assign s_axis_tready = (uop.op == OP_LOAD);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (uop.op == OP_OUT) && !jump;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // ---------------- config registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THRESHOLD_RST;
            r_atk   <= ATTACK_RST;
            r_rel   <= RELEASE_RST;
            r_slope <= SLOPE_RST;
            r_scale <= SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_THRESHOLD: r_thr   <= i_cfg_wdata[ENV_W-1:0];
                REG_ATTACK:    r_atk   <= i_cfg_wdata[COEF_W-1:0];
                REG_RELEASE:   r_rel   <= i_cfg_wdata[COEF_W-1:0];
                REG_SLOPE:     r_slope <= i_cfg_wdata[SLOPE_W-1:0];
                REG_SCALE:     r_scale <= i_cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- magnitude window ----------------
    assign ram_we = (uop.op == OP_SUM);

    src_ram #(
        .WIDTH (WIN_W),
        .DEPTH (WINDOW_LEN)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata ({r_mag_r, r_mag_l}),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // slot average; an empty slot counts as zero
    always_comb begin
        old_pair = {1'b0, ram_rdata[MAG_W-1:0]} + {1'b0, ram_rdata[WIN_W-1:MAG_W]};
        new_pair = {1'b0, r_mag_l} + {1'b0, r_mag_r};
        old_avg  = r_valid[r_ptr] ? old_pair[MAG_W:1] : '0;
        n_sum    = r_sum - SUM_W'(old_avg) + SUM_W'(new_pair[MAG_W:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_valid <= '0;
            r_sum   <= '0;
            r_env   <= '0;
        end else begin
            if (ram_we) begin
                r_valid[r_ptr] <= 1'b1;
                r_sum          <= n_sum;
                r_ptr          <= (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
            end
            if (uop.op == OP_ENV) begin
                r_env <= env_sum[ENV_W-1:0];
            end
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        coef_raw = (r_diff > 18'sd0) ? r_atk : r_rel;
        coef     = (coef_raw > UNITY) ? UNITY : coef_raw;
        case (uop.mul)
            MUL_LEVEL: begin
                op_a = $signed({{(OPA_W-SUM_W){1'b0}}, r_sum});
                op_b = $signed({{(OPB_W-SCALE_W){1'b0}}, r_scale});
            end
            MUL_ENV: begin
                op_a = $signed({{(OPA_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff});
                op_b = $signed({{(OPB_W-COEF_W){1'b0}}, coef});
            end
            MUL_CUT: begin
                op_a = $signed({{(OPA_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff});
                op_b = $signed({{(OPB_W-SLOPE_W){1'b0}}, r_slope});
            end
            MUL_LEFT: begin
                op_a = $signed({{(OPA_W-SAMPLE_W){r_left[SAMPLE_W-1]}}, r_left});
                op_b = $signed({{(OPB_W-GAIN_W){1'b0}}, r_gain});
            end
            MUL_RIGHT: begin
                op_a = $signed({{(OPA_W-SAMPLE_W){r_right[SAMPLE_W-1]}}, r_right});
                op_b = $signed({{(OPB_W-GAIN_W){1'b0}}, r_gain});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // env + floor(coef * (level - env) / 1024) == weighted mix of the two
    assign env_sum = $signed({{(PROD_W-FRAC-ENV_W){1'b0}}, r_env})
                   + $signed(r_prod[PROD_W-1:FRAC]);
    assign cut     = r_prod[CUT_FRAC+ENV_W-1:CUT_FRAC];

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_left  <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
            r_right <= $signed(s_axis_tdata[TDATA_W-1:SAMPLE_W]);
            r_mag_l <= mag15($signed(s_axis_tdata[SAMPLE_W-1:0]));
            r_mag_r <= mag15($signed(s_axis_tdata[TDATA_W-1:SAMPLE_W]));
        end
        if (uop.mul != MUL_NONE) begin
            r_prod <= op_a * op_b;
        end
        case (uop.op)
            OP_DIFF_LVL: r_diff <= $signed({1'b0, r_prod[FRAC+ENV_W-1:FRAC]})
                                 - $signed({1'b0, r_env});
            OP_DIFF_THR: r_diff <= $signed({1'b0, r_env}) - $signed({1'b0, r_thr});
            OP_GAIN: begin
                if (r_diff <= 18'sd0) begin
                    r_gain <= UNITY;
                end else if (cut >= CUT_UNITY) begin
                    r_gain <= '0;
                end else begin
                    r_gain <= GAIN_W'(CUT_UNITY - cut);
                end
            end
            OP_HOLD_L: r_res_l <= r_prod[FRAC+SAMPLE_W-1:FRAC];
            default: ;
        endcase
        if (out_load) begin
            r_out <= {r_prod[FRAC+SAMPLE_W-1:FRAC], r_res_l};
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

endmodule
`default_nettype wire

/* rtl/src_chk.sv */
`default_nettype none
`include "stereo_rms_compressor_top_macros.svh"
module src_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [src_pkg::TDATA_W-1:0] m_axis_tdata
);

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // stalled result beat holds
    `SRC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
    // one pair at a time: ready drops right after a take
    `SRC_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, in_beat, !s_axis_tready, "second pair taken while busy")
    // a new result comes out as the program returns to idle
    `SRC_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, $rose(m_axis_tvalid), s_axis_tready, "result appeared while not idle")
    // reset empties the output register
    `SRC_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid, "output valid after reset")

endmodule

bind stereo_rms_compressor_top src_chk u_src_chk (.*);
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
    import src_pkg::*;

    localparam int WIN          = WINDOW_LEN_DEF;
    localparam int LIMIT_CYCLES = 250000;
    localparam int SETTLE       = 2 * (PROG_LAST + 1);   // settle time after draining, sized from the program length
    localparam int NUM_REGS     = 2 ** CFG_AW;
    localparam int MAX_PRINTS   = 60;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_AW-1:0]    i_cfg_addr;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata;    // [15:0] left_in, [31:16] right_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;    // [15:0] left_out, [31:16] right_out

    stereo_rms_compressor_top #(
        .WINDOW_LEN (WIN)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Clock, cycle counter and watchdog
    // ------------------------------------------------------------------
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    int unsigned cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Compressor predictor: own copy of registers and detector state
    // ------------------------------------------------------------------
    logic [ENV_W-1:0]   thr_m;
    logic [COEF_W-1:0]  att_m;
    logic [COEF_W-1:0]  rel_m;
    logic [SLOPE_W-1:0] slope_m;
    logic [SCALE_W-1:0] scale_m;

    logic [MAG_W-1:0]   win_left  [WIN];
    logic [MAG_W-1:0]   win_right [WIN];
    int unsigned        slot_m;
    int unsigned        sum_m;      // 21-bit running sum of slot averages
    int unsigned        env_m;      // 17-bit envelope

    function automatic void reset_model();
        thr_m   = THRESHOLD_RST;
        att_m   = ATTACK_RST;
        rel_m   = RELEASE_RST;
        slope_m = SLOPE_RST;
        scale_m = SCALE_RST;
        for (int k = 0; k < WIN; k++) begin
            win_left[k]  = '0;
            win_right[k] = '0;
        end
        slot_m = 0;
        sum_m  = 0;
        env_m  = 0;
    endfunction

    // register write as the block sees it: masked to width, unknown index dropped
    function automatic void model_reg_write(input logic [CFG_AW-1:0] idx,
                                            input logic [CFG_W-1:0] val);
        case (idx)
            REG_THRESHOLD: thr_m   = val[ENV_W-1:0];
            REG_ATTACK:    att_m   = val[COEF_W-1:0];
            REG_RELEASE:   rel_m   = val[COEF_W-1:0];
            REG_SLOPE:     slope_m = val[SLOPE_W-1:0];
            REG_SCALE:     scale_m = val[SCALE_W-1:0];
            default: ;
        endcase
    endfunction

    // |x| clipped to 15 bits (most negative code saturates)
    function automatic logic [MAG_W-1:0] sample_mag(input logic signed [SAMPLE_W-1:0] x);
        int v;
        v = x;
        if (v < 0) v = -v;
        if (v > 32767) v = 32767;
        return v[MAG_W-1:0];
    endfunction

    // floor(x * gain / 1024)
    function automatic logic [SAMPLE_W-1:0] gained(input logic signed [SAMPLE_W-1:0] x,
                                                   input int gain);
        longint p;
        p = longint'(x) * longint'(gain);
        return SAMPLE_W'(p >>> FRAC);
    endfunction

    function automatic logic [TDATA_W-1:0] compress_pair(input logic [TDATA_W-1:0] beat);
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        int unsigned lvl;
        int unsigned coef;
        int unsigned cut;
        int          gain;
        l = beat[SAMPLE_W-1:0];
        r = beat[TDATA_W-1:SAMPLE_W];

        // ring window: retire the old slot average, insert the new one
        sum_m = sum_m - ((int'(win_left[slot_m]) + int'(win_right[slot_m])) >> 1);
        win_left[slot_m]  = sample_mag(l);
        win_right[slot_m] = sample_mag(r);
        sum_m = sum_m + ((int'(win_left[slot_m]) + int'(win_right[slot_m])) >> 1);
        sum_m = sum_m & 32'h001F_FFFF;
        slot_m = (slot_m == WIN - 1) ? 0 : slot_m + 1;

        // level detector and attack/release smoothing
        lvl  = (sum_m * int'(scale_m)) >> FRAC;
        coef = (lvl > env_m) ? int'(att_m) : int'(rel_m);
        if (coef > UNITY) coef = 32'(UNITY);
        env_m = ((coef * lvl + (UNITY - coef) * env_m) >> FRAC) & 32'h0001_FFFF;

        // static curve above threshold
        gain = int'(UNITY);
        if (env_m > thr_m) begin
            cut  = (int'(slope_m) * (env_m - int'(thr_m))) >> CUT_FRAC;
            gain = (cut >= UNITY) ? 0 : int'(UNITY) - int'(cut);
        end
        return {gained(r, gain), gained(l, gain)};
    endfunction

    // ------------------------------------------------------------------
    // Queues and error bookkeeping
    // ------------------------------------------------------------------
    logic [TDATA_W-1:0] pending_pairs [$];    // stimulus not yet offered
    logic [TDATA_W-1:0] predicted_out [$];    // expected output beats, oldest first
    int                 errors   = 0;
    int                 idle_pct = 11;
    bit                 pair_taken = 1'b0;

    task automatic flag_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                 input logic [SAMPLE_W-1:0] got);
        if (errors < MAX_PRINTS)
            $display("MISMATCH @%0d %s: expected %0d got %0d", cycle_cnt, what,
                     $signed(want), $signed(got));
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers pending pairs, changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // a new beat goes out only once the current one has been taken
            if (!s_axis_tvalid || pair_taken) begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_pairs.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            pair_taken = 1'b0;
        end
    end

    // output side back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_monitor
        logic [TDATA_W-1:0] want;
        if (i_rst_n) begin
            // check the output first so a beat taken in the same cycle cannot
            // stand in for a missing expectation
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_out.size() == 0) begin
                    flag_mismatch("output beat with nothing pending", '0,
                                  m_axis_tdata[SAMPLE_W-1:0]);
                end else begin
                    want = predicted_out.pop_front();
                    if (m_axis_tdata[SAMPLE_W-1:0] !== want[SAMPLE_W-1:0])
                        flag_mismatch("left_out", want[SAMPLE_W-1:0],
                                      m_axis_tdata[SAMPLE_W-1:0]);
                    if (m_axis_tdata[TDATA_W-1:SAMPLE_W] !== want[TDATA_W-1:SAMPLE_W])
                        flag_mismatch("right_out", want[TDATA_W-1:SAMPLE_W],
                                      m_axis_tdata[TDATA_W-1:SAMPLE_W]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_out.push_back(compress_pair(s_axis_tdata));
                pair_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_pair(input int l, input int r);
        pending_pairs.push_back({SAMPLE_W'(r), SAMPLE_W'(l)});
    endtask

    // signed sample of magnitude between lo and hi, random sign
    function automatic int rand_sample(input int lo, input int hi);
        int m;
        m = $urandom_range(hi, lo);
        if ($urandom_range(1)) return (m > 32768) ? -32768 : -m;
        return (m > 32767) ? 32767 : m;
    endfunction

    // bursts of program material so the envelope crosses the threshold
    // in both directions and the window wraps many times
    task automatic push_program(input int count);
        int n;
        int len;
        int kind;
        int amp;
        n = 0;
        while (n < count) begin
            len  = $urandom_range(80, 4);
            kind = $urandom_range(5);
            amp  = $urandom_range(32768, 64);
            for (int k = 0; k < len && n < count; k++) begin
                case (kind)
                    0: pending_pairs.push_back($urandom);
                    1: push_pair(rand_sample(24000, 32768), rand_sample(24000, 32768));
                    2: push_pair(rand_sample(0, 300), rand_sample(0, 300));
                    3: begin
                        if (k[0]) push_pair(rand_sample(16000, 32768), 0);
                        else      push_pair(0, rand_sample(16000, 32768));
                    end
                    4: begin
                        // square tone: alternating polarity
                        if (k[0]) push_pair(amp > 32767 ? 32767 : amp, -amp);
                        else      push_pair(-amp, amp > 32767 ? 32767 : amp);
                    end
                    default: push_pair(rand_sample(0, amp), rand_sample(0, amp));
                endcase
                n++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        model_reg_write(idx, val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // unused indexes must leave every register alone
    task automatic write_unused_regs();
        for (int a = int'(REG_SCALE) + 1; a < NUM_REGS; a++)
            write_reg(CFG_AW'(a), CFG_W'($urandom));
    endtask

    task automatic random_config();
        write_reg(REG_THRESHOLD, $urandom_range(1) ? CFG_W'($urandom_range(40000))
                                                    : CFG_W'($urandom));
        write_reg(REG_ATTACK,  ($urandom_range(5) == 0) ? CFG_W'($urandom)
                                                         : CFG_W'($urandom_range(1024)));
        write_reg(REG_RELEASE, ($urandom_range(5) == 0) ? CFG_W'($urandom)
                                                         : CFG_W'($urandom_range(1024)));
        write_reg(REG_SLOPE,   ($urandom_range(3) == 0) ? CFG_W'($urandom)
                                                         : CFG_W'($urandom_range(255)));
        write_reg(REG_SCALE,   ($urandom_range(3) == 0) ? CFG_W'($urandom)
                                                         : CFG_W'($urandom_range(63)));
        if ($urandom_range(2) == 0) write_unused_regs();
    endtask

    // wait until every pair went in and every result came out, then let
    // the sequencer run dry before touching registers
    task automatic drain();
        while (pending_pairs.size() != 0 || s_axis_tvalid || predicted_out.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        reset_model();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: field extremes, saturating magnitude, odd averages
        push_pair(0, 0);
        push_pair(32767, 32767);
        push_pair(-32768, -32768);
        push_pair(-32768, 32767);
        push_pair(32767, -32768);
        push_pair(1, 0);
        push_pair(0, 1);
        push_pair(-1, -1);
        push_pair(1, -1);
        push_pair(16'h5555, 16'hAAAA);
        push_pair(16'hAAAA, 16'h5555);
        push_pair(-32768, 0);
        push_pair(0, -32768);
        // sustained full scale drives the envelope up toward the threshold
        repeat (6) push_pair(-32768, -32768);
        push_pair(3, -3);
        push_program(250);
        drain();

        // harshest curve: every unused index first, then registers at extremes
        write_unused_regs();
        write_reg(REG_THRESHOLD, '0);
        write_reg(REG_ATTACK, CFG_W'(UNITY));
        write_reg(REG_RELEASE, CFG_W'(UNITY));
        write_reg(REG_SLOPE, CFG_W'({SLOPE_W{1'b1}}));
        write_reg(REG_SCALE, CFG_W'({SCALE_W{1'b1}}));
        push_program(200);
        drain();

        // frozen envelope, curve out of reach
        write_reg(REG_THRESHOLD, {ENV_W{1'b1}});
        write_reg(REG_ATTACK, '0);
        write_reg(REG_RELEASE, '0);
        write_reg(REG_SLOPE, '0);
        write_reg(REG_SCALE, '0);
        push_program(100);
        drain();

        // over-wide writes: coefficients mask to 2047 and clamp to unity
        write_reg(REG_THRESHOLD, CFG_W'($urandom_range(20000)));
        write_reg(REG_ATTACK, {CFG_W{1'b1}});
        write_reg(REG_RELEASE, {CFG_W{1'b1}});
        write_reg(REG_SLOPE, {CFG_W{1'b1}});
        write_reg(REG_SCALE, {CFG_W{1'b1}});
        repeat (3) push_pair(32767, -32768);
        push_pair(0, 0);
        push_pair(-7, 9);
        push_program(150);
        drain();

        // random settings; one phase runs with no idling on either side
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 2) ? 0 : 11;
            random_config();
            push_program(150);
            drain();
        end
        idle_pct = 11;

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* stereo_rms_compressor_top.f */
+incdir+rtl
rtl/src_pkg.sv
rtl/src_ram.sv
rtl/stereo_rms_compressor_top.sv
rtl/src_chk.sv
sim/tb.sv
